@@ hw/rtl/fesc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the filename escape encoder.
// Used by fesc_front, fesc_queue, fesc_back and filename_escape_encoder.
package fesc_pkg;

	typedef logic [2:0] fesc_kind_t;

	localparam fesc_kind_t KIND_ABSORB = 3'd0;
	localparam fesc_kind_t KIND_PLAIN  = 3'd1;
	localparam fesc_kind_t KIND_UNDER  = 3'd2;
	localparam fesc_kind_t KIND_BYTE   = 3'd3;
	localparam fesc_kind_t KIND_WIDE   = 3'd4;

	typedef logic [1:0] fesc_status_t;

	localparam fesc_status_t STATUS_BUSY   = 2'd0;
	localparam fesc_status_t STATUS_OK     = 2'd1;
	localparam fesc_status_t STATUS_REJECT = 2'd2;

	localparam logic [6:0] CH_NUL   = 7'h00;
	localparam logic [6:0] CH_UNDER = 7'h5f;
	localparam logic [6:0] CH_X     = 7'h78;
	localparam logic [6:0] CH_U     = 7'h75;
	localparam logic [6:0] CH_DASH  = 7'h2d;

	typedef struct packed {
		fesc_kind_t   kind;
		logic [15:0]  unit;
		logic         done;
		fesc_status_t status;
	} fesc_job_t;

	function automatic logic [2:0] kind_len(input fesc_kind_t kind);
		logic [2:0] n;
		unique case (kind)
			KIND_UNDER: n = 3'd2;
			KIND_BYTE:  n = 3'd4;
			KIND_WIDE:  n = 3'd6;
			default:    n = 3'd1;
		endcase
		return n;
	endfunction

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] c;
		if (nib < 4'd10) begin
			c = 7'h30 + {3'b000, nib};
		end else begin
			c = 7'h57 + {3'b000, nib};
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/fesc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts code units, keeps the length counters and the reject flag,
// and turns each unit into an escape job. Depends on fesc_pkg.
module fesc_front #(
	parameter int MAX_LEN = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                in_valid,
	input  logic [15:0]         in_unit,
	input  logic                in_last,
	input  logic                in_empty,
	input  logic                job_ready,
	output logic                job_valid,
	output fesc_pkg::fesc_job_t job
);
	import fesc_pkg::*;

	localparam int ICW = $clog2(MAX_LEN + 2);
	localparam int OCW = $clog2(MAX_LEN + 7);
	localparam int SW  = $clog2(MAX_LEN + 7 + 256);

	logic [7:0]     suffix_q;
	logic [ICW-1:0] in_count_q;
	logic [OCW-1:0] out_count_q;
	logic           rejected_q;

	logic [ICW-1:0] in_next;
	logic [OCW-1:0] out_next;
	logic [SW-1:0]  total;
	logic           rej;
	logic           rej_final;
	logic           done;
	fesc_kind_t     kind;
	logic           accept;

	assign job_valid = in_valid;
	assign accept    = in_valid & job_ready;

	always_comb begin
		in_next  = in_count_q;
		out_next = out_count_q;
		rej      = rejected_q;
		kind     = KIND_ABSORB;
		done     = 1'b1;
		if (in_empty) begin
			if (in_count_q == '0) begin
				rej = 1'b1;
			end
		end else begin
			if (in_count_q <= ICW'(MAX_LEN)) begin
				in_next = in_count_q + 1'b1;
			end
			if (in_next > ICW'(MAX_LEN)) begin
				rej = 1'b1;
			end
			if (out_count_q >= OCW'(MAX_LEN)) begin
				rej = 1'b1;
			end
			if (!rej) begin
				if ((in_unit >= 16'h0030 && in_unit <= 16'h0039) ||
				    (in_unit >= 16'h0061 && in_unit <= 16'h007a) ||
				    in_unit == {9'd0, CH_DASH}) begin
					kind = KIND_PLAIN;
				end else if (in_unit == {9'd0, CH_UNDER}) begin
					kind = KIND_UNDER;
				end else if (in_unit <= 16'h00ff) begin
					kind = KIND_BYTE;
				end else begin
					kind = KIND_WIDE;
				end
				out_next = out_count_q + OCW'(kind_len(kind));
			end
			done = in_last;
		end
		total     = SW'(out_next) + SW'(suffix_q);
		rej_final = rej | (done & (total > SW'(MAX_LEN)));
	end

	always_comb begin
		job.kind   = kind;
		job.unit   = in_unit;
		job.done   = done;
		job.status = done ? (rej_final ? STATUS_REJECT : STATUS_OK) : STATUS_BUSY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suffix_q    <= '0;
			in_count_q  <= '0;
			out_count_q <= '0;
			rejected_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				suffix_q <= cfg_wr_data;
			end
			if (accept) begin
				if (done) begin
					in_count_q  <= '0;
					out_count_q <= '0;
					rejected_q  <= 1'b0;
				end else begin
					in_count_q  <= in_next;
					out_count_q <= out_next;
					rejected_q  <= rej;
				end
			end
		end
	end

endmodule

@@ hw/rtl/fesc_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
// Depends on fesc_pkg for the job type.
module fesc_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  fesc_pkg::fesc_job_t push_job,
	output logic                pop_valid,
	input  logic                pop,
	output fesc_pkg::fesc_job_t pop_job
);
	import fesc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fesc_job_t      store_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = store_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/fesc_back.sv @@
`timescale 1ns / 1ps
// Back end: serializes one escape job into output characters, one per cycle
// when out_ready allows, via a registered output stage. Depends on fesc_pkg.
module fesc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  fesc_pkg::fesc_job_t job,
	output logic                job_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [6:0]          out_char,
	output logic                out_char_valid,
	output logic                out_last_of_run,
	output logic                out_name_done,
	output logic [1:0]          out_status
);
	import fesc_pkg::*;

	logic [2:0]   idx_q;
	logic         valid_q;
	logic [6:0]   char_q;
	logic         char_valid_q;
	logic         last_q;
	logic         done_q;
	fesc_status_t status_q;

	logic [6:0]   ch;
	logic         ch_valid;
	logic         is_last;
	logic         load;

	assign load    = job_valid & (~valid_q | out_ready);
	assign is_last = (idx_q == kind_len(job.kind) - 3'd1);
	assign job_pop = load & is_last;

	always_comb begin
		ch       = CH_NUL;
		ch_valid = 1'b1;
		unique case (job.kind)
			KIND_PLAIN: ch = job.unit[6:0];
			KIND_UNDER: ch = CH_UNDER;
			KIND_BYTE: begin
				unique case (idx_q)
					3'd0:    ch = CH_UNDER;
					3'd1:    ch = CH_X;
					3'd2:    ch = hex_char(job.unit[7:4]);
					default: ch = hex_char(job.unit[3:0]);
				endcase
			end
			KIND_WIDE: begin
				unique case (idx_q)
					3'd0:    ch = CH_UNDER;
					3'd1:    ch = CH_U;
					3'd2:    ch = hex_char(job.unit[15:12]);
					3'd3:    ch = hex_char(job.unit[11:8]);
					3'd4:    ch = hex_char(job.unit[7:4]);
					default: ch = hex_char(job.unit[3:0]);
				endcase
			end
			default: begin
				ch       = CH_NUL;
				ch_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q       <= ch;
			char_valid_q <= ch_valid;
			last_q       <= is_last;
			done_q       <= is_last & job.done;
			status_q     <= (is_last & job.done) ? job.status : STATUS_BUSY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = valid_q;
	assign out_char        = char_q;
	assign out_char_valid  = char_valid_q;
	assign out_last_of_run = last_q;
	assign out_name_done   = done_q;
	assign out_status      = status_q;

endmodule

@@ hw/rtl/filename_escape_encoder.sv @@
`timescale 1ns / 1ps
// Filename escape encoder top level: front end, job queue and back end.
// Depends on fesc_pkg, fesc_front, fesc_queue and fesc_back.

// The block takes one UTF-16 code unit per transaction and emits the escaped
// filename one character per transaction: digits, lower-case letters and '-'
// give one character, '_' gives two, units up to 0xff give four and all others
// give six, while each unit that comes once a name is rejected gives one
// empty result, as does each empty-name mark. The front end accepts a unit
// in every cycle while the job queue (QUEUE_DEPTH entries) has room, so the
// sustained rate is set by the back end, which produces one result per cycle
// while the receiver is ready. The first result of a unit passes through the
// job queue and the back end's registered output stage before it appears.
module filename_escape_encoder #(
	parameter int MAX_LEN     = 255,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,    // suffix_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,        // code_unit
	input  logic        s_tlast,
	input  logic [0:0]  s_tuser,        // empty_name
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,        // out_char, zero pad
	output logic        m_tlast,
	output logic [3:0]  m_tuser         // char_valid, name_done, status[1:0]
);
	import fesc_pkg::*;

	fesc_job_t  front_job;
	fesc_job_t  head_job;
	logic       front_valid;
	logic       queue_ready;
	logic       head_valid;
	logic       head_pop;
	logic [6:0] out_char;
	logic       char_valid;
	logic       name_done;
	logic [1:0] status;

	fesc_front #(
		.MAX_LEN (MAX_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_tvalid),
		.in_unit     (s_tdata),
		.in_last     (s_tlast),
		.in_empty    (s_tuser[0]),
		.job_ready   (queue_ready),
		.job_valid   (front_valid),
		.job         (front_job)
	);

	fesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (queue_ready),
		.push_job   (front_job),
		.pop_valid  (head_valid),
		.pop        (head_pop),
		.pop_job    (head_job)
	);

	fesc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (head_valid),
		.job             (head_job),
		.job_pop         (head_pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_char        (out_char),
		.out_char_valid  (char_valid),
		.out_last_of_run (m_tlast),
		.out_name_done   (name_done),
		.out_status      (status)
	);

	assign s_tready = queue_ready;
	assign m_tdata  = {1'b0, out_char};
	assign m_tuser  = {status, name_done, char_valid};

endmodule

@@ test/fesc_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the filename escape encoder: predicts the output characters of every
// accepted code unit and compares them with the output transactions. Depends on fesc_pkg.
module fesc_checker #(
	parameter int MAX_LEN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tlast,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	input  logic [3:0]  m_tuser,
	output int unsigned errors,
	output int unsigned pending,
	output int unsigned results_checked,
	output int unsigned units_seen,
	output int unsigned names_accepted,
	output int unsigned names_rejected
);
	import fesc_pkg::*;

	localparam logic [6:0] DIGIT_ZERO = 7'h30;
	localparam logic [6:0] DIGIT_NINE = 7'h39;
	localparam logic [6:0] LETTER_A   = 7'h61;
	localparam logic [6:0] LETTER_Z   = 7'h7a;

	typedef struct packed {
		logic [6:0]   ch;
		logic         valid;
		logic         run_end;
		logic         name_end;
		fesc_status_t status;
	} esc_char_t;

	esc_char_t   expected_chars[$];
	logic [7:0]  suffix_len = '0;
	int unsigned chars_in_name = 0;
	int unsigned units_in_name = 0;
	logic        name_rejected = 1'b0;
	int unsigned mismatches = 0;
	int unsigned checked = 0;
	int unsigned units = 0;
	int unsigned accepted_count = 0;
	int unsigned rejected_count = 0;

	function automatic esc_char_t shown(input logic [6:0] c);
		esc_char_t r;
		r = '0;
		r.ch = c;
		r.valid = 1'b1;
		r.status = STATUS_BUSY;
		return r;
	endfunction

	function automatic logic [6:0] hex_digit(input logic [3:0] nib);
		return (nib < 4'd10) ? DIGIT_ZERO + 7'(nib) : LETTER_A + 7'(nib) - 7'd10;
	endfunction

	// Works out the characters that one accepted input transaction produces and
	// advances the per-name counters.
	task automatic escape_unit(input logic [15:0] code, input logic is_last,
			input logic is_empty);
		esc_char_t   seq [6];
		int unsigned n;
		logic        ends_name;
		n = 0;
		foreach (seq[i]) seq[i] = '0;
		if (is_empty) begin
			if (units_in_name == 0) name_rejected = 1'b1;
			n = 1;
			ends_name = 1'b1;
		end else begin
			if (units_in_name <= MAX_LEN) units_in_name++;
			if (units_in_name > MAX_LEN || chars_in_name >= MAX_LEN) name_rejected = 1'b1;
			if (name_rejected) begin
				n = 1;
			end else if ((code >= DIGIT_ZERO && code <= DIGIT_NINE)
					|| (code >= LETTER_A && code <= LETTER_Z) || code == CH_DASH) begin
				seq[0] = shown(code[6:0]);
				n = 1;
			end else if (code == CH_UNDER) begin
				seq[0] = shown(CH_UNDER);
				seq[1] = shown(CH_UNDER);
				n = 2;
			end else if (code <= 16'h00ff) begin
				seq[0] = shown(CH_UNDER);
				seq[1] = shown(CH_X);
				seq[2] = shown(hex_digit(code[7:4]));
				seq[3] = shown(hex_digit(code[3:0]));
				n = 4;
			end else begin
				seq[0] = shown(CH_UNDER);
				seq[1] = shown(CH_U);
				seq[2] = shown(hex_digit(code[15:12]));
				seq[3] = shown(hex_digit(code[11:8]));
				seq[4] = shown(hex_digit(code[7:4]));
				seq[5] = shown(hex_digit(code[3:0]));
				n = 6;
			end
			if (!name_rejected) chars_in_name += n;
			ends_name = is_last;
		end
		seq[n - 1].run_end = 1'b1;
		if (ends_name) begin
			if (!name_rejected && chars_in_name + suffix_len > MAX_LEN) name_rejected = 1'b1;
			seq[n - 1].name_end = 1'b1;
			seq[n - 1].status = name_rejected ? STATUS_REJECT : STATUS_OK;
			if (name_rejected) begin
				rejected_count++;
			end else begin
				accepted_count++;
			end
			chars_in_name = 0;
			units_in_name = 0;
			name_rejected = 1'b0;
		end
		for (int i = 0; i < n; i++) expected_chars.push_back(seq[i]);
	endtask

	task automatic report_bad(input string what, input esc_char_t want);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s at output transaction %0d: expected char %02h valid %0b last %0b",
				what, checked, want.ch, want.valid, want.run_end);
			$display("    done %0b status %0d, got tdata %02h tlast %0b tuser %04b",
				want.name_end, want.status, m_tdata, m_tlast, m_tuser);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		esc_char_t want;
		if (!arst_n) begin
			expected_chars.delete();
			suffix_len = '0;
			chars_in_name = 0;
			units_in_name = 0;
			name_rejected = 1'b0;
			errors <= 0;
			pending <= 0;
			results_checked <= 0;
			units_seen <= 0;
			names_accepted <= 0;
			names_rejected <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				checked++;
				if (expected_chars.size() == 0) begin
					report_bad("Unexpected transaction", '0);
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata[6:0] !== want.ch || m_tdata[7] !== 1'b0
							|| m_tuser[0] !== want.valid || m_tlast !== want.run_end
							|| m_tuser[1] !== want.name_end || m_tuser[3:2] !== want.status) begin
						report_bad("Mismatch", want);
					end
				end
			end
			if (cfg_wr_en) suffix_len = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				units++;
				escape_unit(s_tdata, s_tlast, s_tuser[0]);
			end
			errors <= mismatches;
			pending <= expected_chars.size();
			results_checked <= checked;
			units_seen <= units;
			names_accepted <= accepted_count;
			names_rejected <= rejected_count;
		end
	end

endmodule

@@ test/tb_filename_escape_encoder.sv @@
`timescale 1ns / 1ps
// Testbench top for the filename escape encoder: drives directed and random names with
// random stalls on both streams and reports the verdict. Depends on fesc_pkg and fesc_checker.
module tb_filename_escape_encoder;

	import fesc_pkg::*;

	localparam int          MAX_LEN     = 255;
	localparam int unsigned LONG_HOLD   = 120;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam logic [15:0] DIGIT_ZERO  = 16'h0030;
	localparam logic [15:0] LETTER_A    = 16'h0061;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [3:0]  m_tuser;

	int unsigned errors;
	int unsigned pending;
	int unsigned results_checked;
	int unsigned units_seen;
	int unsigned names_accepted;
	int unsigned names_rejected;

	logic        send_burst = 1'b0;
	logic        recv_burst = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned holds_done = 0;
	int unsigned cycles = 0;

	filename_escape_encoder #(
		.MAX_LEN(MAX_LEN),
		.QUEUE_DEPTH(4)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	fesc_checker #(
		.MAX_LEN(MAX_LEN)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.errors(errors),
		.pending(pending),
		.results_checked(results_checked),
		.units_seen(units_seen),
		.names_accepted(names_accepted),
		.names_rejected(names_rejected)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [15:0] pick_unit(input fesc_kind_t kind);
		int unsigned r;
		logic [15:0] code;
		case (kind)
			KIND_PLAIN: begin
				r = $urandom_range(0, 36);
				if (r < 10) begin
					code = DIGIT_ZERO + 16'(r);
				end else if (r < 36) begin
					code = LETTER_A + 16'(r - 10);
				end else begin
					code = {9'd0, CH_DASH};
				end
			end
			KIND_UNDER: code = {9'd0, CH_UNDER};
			KIND_BYTE:  code = 16'($urandom_range(0, 255));
			default:    code = 16'($urandom_range(16'h0100, 16'hffff));
		endcase
		return code;
	endfunction

	task automatic send_item(input logic [15:0] code, input logic is_last, input logic is_empty);
		int unsigned gap;
		gap = send_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= code;
		s_tlast <= is_last;
		s_tuser <= is_empty;
		do @(posedge clk); while (!s_tready);
	endtask

	// Mostly well-formed names of mixed content; some are empty and some end
	// with an empty-name mark instead of a last unit.
	task automatic send_random_name();
		int unsigned len;
		int unsigned shape;
		int unsigned r;
		fesc_kind_t  kind;
		logic [15:0] code;
		len = $urandom_range(1, 12);
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			send_item(16'($urandom), 1'($urandom), 1'b1);
			return;
		end
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 19);
			kind = (r < 8) ? KIND_PLAIN : (r < 11) ? KIND_UNDER : (r < 15) ? KIND_BYTE : KIND_WIDE;
			code = (r >= 18) ? 16'($urandom) : pick_unit(kind);
			send_item(code, (i == len - 1) && shape != 1, 1'b0);
		end
		if (shape == 1) send_item(16'($urandom), 1'($urandom), 1'b1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_suffix(input logic [7:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int unsigned gap;
		m_tready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			gap = recv_burst ? 0 : $urandom_range(0, 9);
			if (holds_done != hold_requests) begin
				holds_done++;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		s_tuser <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Suffix length at its reset value: every character class and its edges.
		send_item(16'h0030, 1'b0, 1'b0);
		send_item(16'h0039, 1'b0, 1'b0);
		send_item(16'h0061, 1'b0, 1'b0);
		send_item(16'h007a, 1'b0, 1'b0);
		send_item({9'd0, CH_DASH}, 1'b0, 1'b0);
		send_item({9'd0, CH_UNDER}, 1'b1, 1'b0);
		send_item(16'h0000, 1'b0, 1'b0);
		send_item(16'h002f, 1'b0, 1'b0);
		send_item(16'h003a, 1'b0, 1'b0);
		send_item(16'h0060, 1'b0, 1'b0);
		send_item(16'h007b, 1'b0, 1'b0);
		send_item(16'h0041, 1'b0, 1'b0);
		send_item(16'h00ff, 1'b0, 1'b0);
		send_item(16'h0100, 1'b0, 1'b0);
		send_item(16'hffff, 1'b1, 1'b0);
		send_item(16'hffff, 1'b1, 1'b1);
		send_item(16'h0061, 1'b0, 1'b0);
		send_item(16'h0062, 1'b0, 1'b0);
		send_item(16'h0000, 1'b0, 1'b1);
		send_item(16'h0078, 1'b1, 1'b0);

		// The longest suffix rejects every name at its end.
		write_suffix(8'd255);
		send_item(16'h0061, 1'b1, 1'b0);
		send_item({9'd0, CH_UNDER}, 1'b1, 1'b0);
		send_item(16'h0000, 1'b0, 1'b1);
		send_item(16'hffff, 1'b1, 1'b0);

		// Overlong names: too many units, then a full output. The receiver holds
		// off at the start while the sender keeps offering units.
		write_suffix(8'd0);
		send_burst = 1'b1;
		hold_requests++;
		for (int i = 0; i < 257; i++) begin
			if (i == 40) send_burst = 1'b0;
			send_item(pick_unit(KIND_PLAIN), i == 256, 1'b0);
		end
		for (int i = 0; i < 46; i++) begin
			send_item(pick_unit(KIND_WIDE), i == 45, 1'b0);
		end

		// Suffix lengths that put the final length check near the names' sizes.
		for (int p = 0; p < 4; p++) begin
			write_suffix(8'($urandom_range(190, 250)));
			send_burst = (p == 2);
			recv_burst = (p == 2);
			repeat (2) send_random_name();
		end
		send_burst = 1'b0;
		recv_burst = 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d code units in %0d names (%0d accepted, %0d rejected).",
			units_seen, names_accepted + names_rejected, names_accepted, names_rejected);
		$display("Checked %0d output transactions over suffix lengths 0, 255 and 190..250.",
			results_checked);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
